// File: design/lp_norm_axis_reduce_assert.svh
// Assertion macros shared by the norm reduction block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LP_NORM_AXIS_REDUCE_ASSERT_SVH
`define LP_NORM_AXIS_REDUCE_ASSERT_SVH

// Same-cycle implication.
`define LPN_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define LPN_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: design/lpn_pkg.sv
// Shared constants and types for the norm reduction block.
// No dependencies.
`timescale 1ns / 1ps

package lpn_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int INNER_MAX   = 1024;
	localparam int SLOT_W      = $clog2(INNER_MAX);
	localparam int ACC_W       = 48;
	localparam int TERM_W      = 2 * SAMPLE_BITS;
	localparam int NORM_W      = 32;
	localparam int ROOT_W      = ACC_W / 2;
	localparam int LEN_W       = 17;
	localparam int ILEN_W      = 11;
	localparam int POS_W       = 16;
	localparam int MODE_W      = 2;
	localparam int LEN_MAX     = 65536;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [MODE_W-1:0] MODE_L1 = 2'd1;

	localparam logic [1:0] REG_P_MODE    = 2'd0;
	localparam logic [1:0] REG_AXIS_LEN  = 2'd1;
	localparam logic [1:0] REG_INNER_LEN = 2'd2;
	localparam logic [1:0] REG_OUTER_LEN = 2'd3;

	typedef struct packed {
		logic              mode1;
		logic [POS_W-1:0]  alen_m1;
		logic [SLOT_W-1:0] ilen_m1;
		logic [POS_W-1:0]  olen_m1;
	} cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TERM_W-1:0] term;
		logic              zero;
	} acc_req_t;

endpackage

// File: design/lpn_cfg_regs.sv
// Configuration registers behind the APB-style port, with effective lengths.
// Depends on lpn_pkg.
`timescale 1ns / 1ps

module lpn_cfg_regs import lpn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic [MODE_W-1:0] p_mode_q;
	logic [LEN_W-1:0]  axis_len_q;
	logic [ILEN_W-1:0] inner_len_q;
	logic [LEN_W-1:0]  outer_len_q;
	logic [1:0]        index;
	logic              wr_en;

	assign index = paddr[ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_mode_q    <= MODE_W'(2);
			axis_len_q  <= LEN_W'(1);
			inner_len_q <= ILEN_W'(1);
			outer_len_q <= LEN_W'(1);
		end else if (wr_en) begin
			unique case (index)
				REG_P_MODE:    p_mode_q    <= pwdata[MODE_W-1:0];
				REG_AXIS_LEN:  axis_len_q  <= pwdata[LEN_W-1:0];
				REG_INNER_LEN: inner_len_q <= pwdata[ILEN_W-1:0];
				REG_OUTER_LEN: outer_len_q <= pwdata[LEN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_P_MODE:    prdata = DATA_W'(p_mode_q);
			REG_AXIS_LEN:  prdata = DATA_W'(axis_len_q);
			REG_INNER_LEN: prdata = DATA_W'(inner_len_q);
			REG_OUTER_LEN: prdata = DATA_W'(outer_len_q);
		endcase
	end

	// A zero length acts as one; an oversized length saturates.
	always_comb begin
		cfg.mode1 = (p_mode_q == MODE_L1);
		if (axis_len_q == '0)
			cfg.alen_m1 = '0;
		else if (axis_len_q > LEN_W'(LEN_MAX))
			cfg.alen_m1 = POS_W'(LEN_MAX - 1);
		else
			cfg.alen_m1 = POS_W'(axis_len_q - LEN_W'(1));
		if (inner_len_q == '0)
			cfg.ilen_m1 = '0;
		else if (inner_len_q > ILEN_W'(INNER_MAX))
			cfg.ilen_m1 = SLOT_W'(INNER_MAX - 1);
		else
			cfg.ilen_m1 = SLOT_W'(inner_len_q - ILEN_W'(1));
		if (outer_len_q == '0)
			cfg.olen_m1 = '0;
		else if (outer_len_q > LEN_W'(LEN_MAX))
			cfg.olen_m1 = POS_W'(LEN_MAX - 1);
		else
			cfg.olen_m1 = POS_W'(outer_len_q - LEN_W'(1));
	end

endmodule

// File: design/lpn_accum.sv
// Accumulator memory with a registered read and a saturating write-back.
// Depends on lpn_pkg.
`timescale 1ns / 1ps

module lpn_accum import lpn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  acc_req_t         req,
	output logic [ACC_W-1:0] sum
);

	logic [ACC_W-1:0] mem [INNER_MAX];
	logic [ACC_W-1:0] rd_s1;
	acc_req_t         req_s1;
	logic             wr_s1;
	logic [ACC_W:0]   ext;

	assign ext = {1'b0, rd_s1} + (ACC_W + 1)'(req_s1.term);

	// The first axis step overwrites whatever the entry held.
	always_comb begin
		if (req_s1.zero)
			sum = ACC_W'(req_s1.term);
		else if (ext[ACC_W])
			sum = '1;
		else
			sum = ext[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_s1 <= 1'b0;
		else
			wr_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			rd_s1  <= mem[req.slot];
			req_s1 <= req;
		end
		if (wr_s1)
			mem[req_s1.slot] <= sum;
	end

endmodule

// File: design/lpn_sqrt.sv
// Bit-serial floor square root of the accumulated sum, one result bit a step.
// Depends on lpn_pkg.
`timescale 1ns / 1ps

module lpn_sqrt import lpn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  operand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] res_q;
	logic [ACC_W-1:0] bit_q;
	logic [ACC_W-1:0] trial;
	logic             take;
	logic             busy_q;
	logic             done_q;

	assign trial = res_q + bit_q;
	assign take  = (rem_q >= trial);
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q & bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// File: design/lp_norm_axis_reduce.sv
// Top level of the streaming L1 / L2 norm reduction along one tensor axis.
// Depends on lpn_pkg, lpn_cfg_regs, lpn_accum, lpn_sqrt and the assertion macro header.
`timescale 1ns / 1ps
`include "lp_norm_axis_reduce_assert.svh"

// Elements are taken one at a time. An element that completes no norm occupies the block
// for the accumulator read on acceptance and the add and write-back in ST_ACC. A completing
// element then waits in ST_OUT until the output register is free; with the root of the sum
// of squares it first passes through ST_ROOT, where the bit-serial root unit resolves two
// bits of the sum per cycle over 24 steps. The finished norm waits in an output register,
// so a new element is taken while that beat is still pending. Accumulators need no
// clearing after reset, as each one is overwritten at the first step along the axis.
module lp_norm_axis_reduce import lpn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
	input  logic                   s_tuser,   // [0] first
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [NORM_W-1:0]      m_tdata,   // [31:0] norm
	output logic                   m_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	cfg_t                   cfg;
	acc_req_t               req;
	logic [1:0]             state_q;
	logic [POS_W-1:0]       axis_q;
	logic [SLOT_W-1:0]      inner_q;
	logic [POS_W-1:0]       outer_q;
	logic [POS_W-1:0]       cur_axis;
	logic [SLOT_W-1:0]      cur_inner;
	logic [POS_W-1:0]       cur_outer;
	logic                   emit;
	logic                   inner_end;
	logic                   emit_q;
	logic                   last_q;
	logic                   mode1_q;
	logic                   s_accept;
	logic                   out_free;
	logic [SAMPLE_BITS-1:0] mag;
	logic [TERM_W-1:0]      sq;
	logic [ACC_W-1:0]       sum;
	logic [NORM_W-1:0]      sum_sat;
	logic [NORM_W-1:0]      norm_q;
	logic                   root_start;
	logic                   root_done;
	logic [ROOT_W-1:0]      root;
	logic                   m_tvalid_q;
	logic [NORM_W-1:0]      m_tdata_q;
	logic                   m_tlast_q;

	lpn_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign cur_axis  = s_tuser ? '0 : axis_q;
	assign cur_inner = s_tuser ? '0 : inner_q;
	assign cur_outer = s_tuser ? '0 : outer_q;
	assign emit      = (cur_axis >= cfg.alen_m1);
	assign inner_end = (cur_inner >= cfg.ilen_m1);

	assign mag = s_tdata[SAMPLE_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;
	assign sq  = mag * mag;

	always_comb begin
		req.slot = cur_inner;
		req.term = cfg.mode1 ? TERM_W'(mag) : sq;
		req.zero = (cur_axis == '0);
	end

	lpn_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_accept),
		.req       (req),
		.sum       (sum)
	);

	assign sum_sat    = (|sum[ACC_W-1:NORM_W]) ? '1 : sum[NORM_W-1:0];
	assign root_start = (state_q == ST_ACC) && emit_q && !mode1_q;

	lpn_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (sum),
		.done    (root_done),
		.root    (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			inner_q <= '0;
			outer_q <= '0;
			emit_q  <= 1'b0;
			last_q  <= 1'b0;
			mode1_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						emit_q  <= emit;
						last_q  <= (cur_outer >= cfg.olen_m1) && inner_end;
						mode1_q <= cfg.mode1;
						state_q <= ST_ACC;
						if (inner_end) begin
							inner_q <= '0;
							if (emit) begin
								axis_q  <= '0;
								outer_q <= (cur_outer >= cfg.olen_m1) ? '0
									: cur_outer + POS_W'(1);
							end else begin
								axis_q  <= cur_axis + POS_W'(1);
								outer_q <= cur_outer;
							end
						end else begin
							inner_q <= cur_inner + SLOT_W'(1);
							axis_q  <= cur_axis;
							outer_q <= cur_outer;
						end
					end
				end
				ST_ACC: begin
					if (!emit_q)
						state_q <= ST_IDLE;
					else if (mode1_q)
						state_q <= ST_OUT;
					else
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && mode1_q)
			norm_q <= sum_sat;
		else if (state_q == ST_ROOT && root_done)
			norm_q <= NORM_W'(root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= norm_q;
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`LPN_ASSERT_IMP(a_root_done_in_root, root_done, state_q == ST_ROOT, "root finished outside root state")
	`LPN_ASSERT_IMP(a_beat_from_out, $rose(m_tvalid_q), $past(state_q) == ST_OUT, "output beat without result")
	`LPN_ASSERT_NXT(a_l1_skips_root, state_q == ST_ACC && mode1_q, state_q != ST_ROOT, "magnitude sum sent to root")

endmodule
